// ===== rtl/ecc_pkg.sv =====
// Package for the elevator car controller: car mode, command and event codes,
// configuration register indexes, floor constants and the call scan helpers.
// Depends on nothing; the controller top level imports it.
package ecc_pkg;

	localparam int FLOOR_COUNT = 10;
	localparam int FLOOR_W     = (FLOOR_COUNT > 1) ? $clog2(FLOOR_COUNT) : 1;

	localparam logic [3:0]         TOP_FLOOR = 4'(FLOOR_COUNT - 1);
	localparam logic [FLOOR_W-1:0] TOP_IDX   = FLOOR_W'(FLOOR_COUNT - 1);

	localparam logic [15:0] DOOR_TIME_RST   = 16'd2000;
	localparam logic [15:0] SETTLE_TIME_RST = 16'd3000;
	localparam logic [15:0] TRAVEL_TIME_RST = 16'd3000;

	localparam logic [1:0] REG_DOOR_TIME   = 2'd0;
	localparam logic [1:0] REG_SETTLE_TIME = 2'd1;
	localparam logic [1:0] REG_TRAVEL_TIME = 2'd2;

	localparam logic signed [1:0] HEAD_UP   = 2'sb01;
	localparam logic signed [1:0] HEAD_NONE = 2'sb00;
	localparam logic signed [1:0] HEAD_DOWN = 2'sb11;

	typedef logic [FLOOR_COUNT-1:0] calls_t;

	// Car mode, kept one-hot inside the block.
	typedef enum logic [6:0] {
		MODE_IDLE     = 7'b0000001,
		MODE_CLOSING  = 7'b0000010,
		MODE_MOVING   = 7'b0000100,
		MODE_ARRIVED  = 7'b0001000,
		MODE_OPENING  = 7'b0010000,
		MODE_OPEN     = 7'b0100000,
		MODE_OVERLOAD = 7'b1000000
	} mode_t;

	typedef enum logic [2:0] {
		CMD_TICK       = 3'd0,
		CMD_FLOOR_CALL = 3'd1,
		CMD_SECURE     = 3'd2,
		CMD_OPEN       = 3'd3,
		CMD_CLOSE      = 3'd4,
		CMD_ESTOP      = 3'd5,
		CMD_WEIGHT     = 3'd6
	} cmd_t;

	typedef enum logic [3:0] {
		EV_NONE     = 4'd0,
		EV_OPENING  = 4'd1,
		EV_CLOSING  = 4'd2,
		EV_TRANSIT  = 4'd3,
		EV_ARRIVED  = 4'd4,
		EV_IDLE     = 4'd5,
		EV_CALL     = 4'd6,
		EV_LOCK     = 4'd7,
		EV_SECURE   = 4'd8,
		EV_UNLOCKED = 4'd9
	} event_t;

	localparam logic [2:0] CODE_IDLE     = 3'd0;
	localparam logic [2:0] CODE_CLOSING  = 3'd1;
	localparam logic [2:0] CODE_MOVING   = 3'd2;
	localparam logic [2:0] CODE_ARRIVED  = 3'd3;
	localparam logic [2:0] CODE_OPENING  = 3'd4;
	localparam logic [2:0] CODE_OPEN     = 3'd5;
	localparam logic [2:0] CODE_OVERLOAD = 3'd6;

	function automatic logic [2:0] mode_code(input mode_t m);
		logic [2:0] c;
		unique case (m)
			MODE_IDLE:     c = CODE_IDLE;
			MODE_CLOSING:  c = CODE_CLOSING;
			MODE_MOVING:   c = CODE_MOVING;
			MODE_ARRIVED:  c = CODE_ARRIVED;
			MODE_OPENING:  c = CODE_OPENING;
			MODE_OPEN:     c = CODE_OPEN;
			MODE_OVERLOAD: c = CODE_OVERLOAD;
			default:       c = CODE_IDLE;
		endcase
		return c;
	endfunction

	// True if any call is pending strictly above the given floor.
	function automatic logic calls_above(input calls_t flags, input logic [3:0] f);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < FLOOR_COUNT; i++) begin
			if (flags[i] && (i > int'(f))) hit = 1'b1;
		end
		return hit;
	endfunction

	// True if any call is pending strictly below the given floor.
	function automatic logic calls_below(input calls_t flags, input logic [3:0] f);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < FLOOR_COUNT; i++) begin
			if (flags[i] && (i < int'(f))) hit = 1'b1;
		end
		return hit;
	endfunction

endpackage

// ===== rtl/elevator_car_controller_unit.sv =====
// Elevator car controller top level: input stage, car state, control logic
// and result register. Depends on ecc_pkg for codes, constants and call scans.
//
// Usage:
// Commands enter on the input channel (in_valid/in_stall with command, floor
// and over_limit). Every accepted transaction yields exactly one result on the
// output channel (out_valid/out_stall with mode, car_floor, direction, locked,
// event_res and floor_passed), in order.
// A command is registered in the input stage on acceptance and processed from
// there, where the car state and the result register are updated together.
// Throughput is one command per cycle while the receiver does not stall; the
// limit is the single pass through the control logic that reads and writes
// the car state.
// When the receiver stalls, the result register holds its transaction and the
// input stage holds one more command; after that in_stall is raised until the
// result is taken.
// The timing registers are written through cfg_write, cfg_index and cfg_data;
// an index past the last register is ignored.
// Reset puts the car idle at floor zero with no direction, no calls, the lock
// clear, the timer at zero and the timing registers at 2000, 3000 and 3000 ms.
module elevator_car_controller_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        command,
	input  logic [3:0]        floor,
	input  logic              over_limit,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        mode,
	output logic [3:0]        car_floor,
	output logic signed [1:0] direction,
	output logic              locked,
	output logic [3:0]        event_res,
	output logic              floor_passed
);
	import ecc_pkg::*;

	// Input stage
	logic        valid_s1;
	cmd_t        command_s1;
	logic [3:0]  floor_s1;
	logic        over_limit_s1;

	// Timing registers
	logic [15:0] door_time_q;
	logic [15:0] settle_time_q;
	logic [15:0] travel_time_q;

	// Car state
	mode_t             car_mode_q;
	logic [3:0]        floor_q;
	logic signed [1:0] heading_q;
	calls_t            calls_q;
	logic [15:0]       elapsed_q;
	logic              lock_q;

	// Result register
	logic              out_valid_q;
	logic [2:0]        res_mode_q;
	logic [3:0]        res_floor_q;
	logic signed [1:0] res_dir_q;
	logic              res_locked_q;
	logic [3:0]        res_event_q;
	logic              res_passed_q;

	// Next state
	mode_t             mode_d;
	mode_t             mode_eff;
	logic [3:0]        floor_d;
	logic [3:0]        floor_step;
	logic signed [1:0] heading_d;
	logic signed [1:0] head_choice;
	calls_t            calls_d;
	logic [15:0]       elapsed_d;
	logic [15:0]       elapsed_inc;
	logic              lock_d;
	event_t            ev_d;
	logic              passed_d;

	logic              above_now;
	logic              below_now;
	logic              above_new;
	logic              below_new;
	logic              ahead_new;
	logic              behind_new;
	logic              advance;
	logic              in_accept;

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	assign above_now = calls_above(calls_q, floor_q);
	assign below_now = calls_below(calls_q, floor_q);

	// Direction choice: keep going while calls lie ahead, else prefer up.
	always_comb begin
		priority if (heading_q == HEAD_UP && above_now) head_choice = HEAD_UP;
		else if (heading_q == HEAD_DOWN && below_now) head_choice = HEAD_DOWN;
		else if (above_now) head_choice = HEAD_UP;
		else if (below_now) head_choice = HEAD_DOWN;
		else head_choice = HEAD_NONE;
	end

	always_comb begin
		priority if (heading_q > 2'sb00 && floor_q < TOP_FLOOR) floor_step = floor_q + 4'd1;
		else if (heading_q < 2'sb00 && floor_q != 4'd0) floor_step = floor_q - 4'd1;
		else floor_step = floor_q;
	end

	assign above_new  = calls_above(calls_q, floor_step);
	assign below_new  = calls_below(calls_q, floor_step);
	assign ahead_new  = (heading_q == HEAD_UP) ? above_new : below_new;
	assign behind_new = (heading_q == HEAD_UP) ? below_new : above_new;

	assign elapsed_inc = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;

	always_comb begin
		mode_d    = car_mode_q;
		mode_eff  = (car_mode_q == MODE_OVERLOAD) ? MODE_IDLE : car_mode_q;
		floor_d   = floor_q;
		heading_d = heading_q;
		calls_d   = calls_q;
		elapsed_d = elapsed_q;
		lock_d    = lock_q;
		ev_d      = EV_NONE;
		passed_d  = 1'b0;

		unique case (command_s1)
			CMD_TICK: begin
				elapsed_d = elapsed_inc;
				if (lock_q) begin
					mode_d = MODE_OVERLOAD;
				end else begin
					// A tick after the lock clears runs the idle logic at once.
					mode_d = mode_eff;
					unique case (mode_eff)
						MODE_IDLE: begin
							if (calls_q[floor_q[FLOOR_W-1:0]]) begin
								calls_d[floor_q[FLOOR_W-1:0]] = 1'b0;
								mode_d    = MODE_OPENING;
								elapsed_d = 16'd0;
								ev_d      = EV_OPENING;
							end else begin
								heading_d = head_choice;
								if (head_choice != HEAD_NONE) begin
									mode_d    = MODE_CLOSING;
									elapsed_d = 16'd0;
									ev_d      = EV_CLOSING;
								end
							end
						end
						MODE_CLOSING: begin
							if (elapsed_inc > door_time_q) begin
								heading_d = head_choice;
								if (head_choice != HEAD_NONE) begin
									mode_d    = MODE_MOVING;
									elapsed_d = 16'd0;
									ev_d      = EV_TRANSIT;
								end else begin
									mode_d = MODE_IDLE;
									ev_d   = EV_IDLE;
								end
							end
						end
						MODE_MOVING: begin
							if (elapsed_inc > travel_time_q) begin
								floor_d   = floor_step;
								elapsed_d = 16'd0;
								passed_d  = (floor_step != floor_q);
								if (calls_q[floor_step[FLOOR_W-1:0]]) begin
									calls_d[floor_step[FLOOR_W-1:0]] = 1'b0;
									mode_d = MODE_ARRIVED;
									ev_d   = EV_ARRIVED;
								end else if (!ahead_new) begin
									if (behind_new) begin
										heading_d = -heading_q;
										ev_d      = EV_TRANSIT;
									end else begin
										mode_d    = MODE_IDLE;
										heading_d = HEAD_NONE;
										ev_d      = EV_IDLE;
									end
								end
							end
						end
						MODE_ARRIVED: begin
							if (elapsed_inc > settle_time_q) begin
								mode_d    = MODE_OPENING;
								elapsed_d = 16'd0;
								ev_d      = EV_OPENING;
							end
						end
						MODE_OPENING: begin
							if (elapsed_inc > door_time_q) begin
								mode_d    = MODE_OPEN;
								elapsed_d = 16'd0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			CMD_FLOOR_CALL: begin
				if (!lock_q && floor_s1 < TOP_FLOOR) begin
					if (floor_s1 == floor_q) begin
						if (car_mode_q == MODE_IDLE) begin
							mode_d    = MODE_OPENING;
							elapsed_d = 16'd0;
							ev_d      = EV_OPENING;
						end
					end else begin
						calls_d[floor_s1[FLOOR_W-1:0]] = 1'b1;
						ev_d = EV_CALL;
					end
				end
			end
			CMD_SECURE: begin
				if (!lock_q) begin
					calls_d[TOP_IDX] = 1'b1;
					ev_d = EV_SECURE;
				end
			end
			CMD_OPEN: begin
				if (car_mode_q == MODE_IDLE || car_mode_q == MODE_OPEN) begin
					mode_d    = MODE_OPENING;
					elapsed_d = 16'd0;
					ev_d      = EV_OPENING;
				end
			end
			CMD_CLOSE: begin
				if (car_mode_q == MODE_OPEN) begin
					mode_d    = MODE_CLOSING;
					elapsed_d = 16'd0;
					ev_d      = EV_CLOSING;
				end
			end
			CMD_ESTOP: begin
				lock_d = 1'b1;
				ev_d   = EV_LOCK;
			end
			CMD_WEIGHT: begin
				priority if (over_limit_s1 && !lock_q) begin
					lock_d = 1'b1;
					ev_d   = EV_LOCK;
				end else if (!over_limit_s1 && lock_q) begin
					lock_d = 1'b0;
					ev_d   = EV_UNLOCKED;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			door_time_q   <= DOOR_TIME_RST;
			settle_time_q <= SETTLE_TIME_RST;
			travel_time_q <= TRAVEL_TIME_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_DOOR_TIME:   door_time_q   <= cfg_data;
				REG_SETTLE_TIME: settle_time_q <= cfg_data;
				REG_TRAVEL_TIME: travel_time_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			command_s1    <= cmd_t'(command);
			floor_s1      <= floor;
			over_limit_s1 <= over_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			car_mode_q <= MODE_IDLE;
			floor_q    <= 4'd0;
			heading_q  <= HEAD_NONE;
			calls_q    <= '0;
			elapsed_q  <= 16'd0;
			lock_q     <= 1'b0;
		end else if (advance) begin
			car_mode_q <= mode_d;
			floor_q    <= floor_d;
			heading_q  <= heading_d;
			calls_q    <= calls_d;
			elapsed_q  <= elapsed_d;
			lock_q     <= lock_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_mode_q   <= mode_code(mode_d);
			res_floor_q  <= floor_d;
			res_dir_q    <= heading_d;
			res_locked_q <= lock_d;
			res_event_q  <= ev_d;
			res_passed_q <= passed_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign mode         = res_mode_q;
	assign car_floor    = res_floor_q;
	assign direction    = res_dir_q;
	assign locked       = res_locked_q;
	assign event_res    = res_event_q;
	assign floor_passed = res_passed_q;

`ifndef NO_ASSERTIONS
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed command did not produce a result");

	a_lock_forces_overload: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && lock_q && command_s1 == CMD_TICK) |=> car_mode_q == MODE_OVERLOAD)
		else $error("tick under lock did not enter overload mode");

	a_floor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		floor_q <= TOP_FLOOR)
		else $error("car floor outside the shaft");

	a_floor_change_flagged: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && floor_d != floor_q) |=> res_passed_q)
		else $error("floor change not reported as floor passed");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for elevator_car_controller_unit: named tests drive commands,
// a predictor tracks the car state and every result transaction is checked in order.
// Depends on ecc_pkg for the command, event, mode and register codes.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ecc_pkg::*;

	localparam logic [2:0]  CMD_UNUSED     = 3'd7;
	localparam logic [1:0]  REG_SPARE      = 2'd3;
	localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;
	localparam int          WATCHDOG_LIMIT = 1000;
	localparam int          REPORT_LIMIT   = 10;

	typedef struct packed {
		logic [2:0] mode;
		logic [3:0] floor;
		logic [1:0] dir;
		logic       locked;
		logic [3:0] ev;
		logic       passed;
	} car_view_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_write;
	logic [1:0]        cfg_index;
	logic [15:0]       cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic [2:0]        command;
	logic [3:0]        floor;
	logic              over_limit;
	logic              out_valid;
	logic              out_stall;
	logic [2:0]        mode;
	logic [3:0]        car_floor;
	logic signed [1:0] direction;
	logic              locked;
	logic [3:0]        event_res;
	logic              floor_passed;

	// Predicted car state and timing registers.
	logic [2:0]        mode_q;
	logic [3:0]        floor_q;
	logic signed [1:0] head_q;
	logic [15:0]       calls_q;
	logic [15:0]       elapsed_q;
	logic              lock_q;
	logic [15:0]       door_ms;
	logic [15:0]       settle_ms;
	logic [15:0]       travel_ms;

	car_view_t views_due[$];
	int        errors = 0;
	int        quiet_cycles = 0;
	int        stall_left = 0;
	bit        idling;

	elevator_car_controller_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.floor        (floor),
		.over_limit   (over_limit),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mode         (mode),
		.car_floor    (car_floor),
		.direction    (direction),
		.locked       (locked),
		.event_res    (event_res),
		.floor_passed (floor_passed)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic pending_up();
		return (calls_q >> (floor_q + 5'd1)) != 16'd0;
	endfunction

	function automatic logic pending_down();
		return (calls_q & ((16'd1 << floor_q) - 16'd1)) != 16'd0;
	endfunction

	// Keep the heading while calls lie ahead, otherwise prefer up over down.
	function automatic void pick_heading();
		logic up, dn;
		up = pending_up();
		dn = pending_down();
		if (!(head_q == HEAD_UP && up) && !(head_q == HEAD_DOWN && dn))
			head_q = up ? HEAD_UP : (dn ? HEAD_DOWN : HEAD_NONE);
	endfunction

	function automatic logic [3:0] run_car_tick(output logic passed);
		logic [3:0] ev;
		logic [3:0] old;
		logic       ahead, behind;
		ev = EV_NONE;
		passed = 1'b0;
		if (elapsed_q != ELAPSED_MAX) elapsed_q++;
		if (lock_q) begin
			mode_q = CODE_OVERLOAD;
			return ev;
		end
		if (mode_q == CODE_OVERLOAD) mode_q = CODE_IDLE;
		case (mode_q)
			CODE_IDLE: begin
				if (calls_q[floor_q]) begin
					calls_q[floor_q] = 1'b0;
					mode_q = CODE_OPENING;
					elapsed_q = '0;
					ev = EV_OPENING;
				end else begin
					pick_heading();
					if (head_q != HEAD_NONE) begin
						mode_q = CODE_CLOSING;
						elapsed_q = '0;
						ev = EV_CLOSING;
					end
				end
			end
			CODE_CLOSING: begin
				if (elapsed_q > door_ms) begin
					pick_heading();
					if (head_q != HEAD_NONE) begin
						mode_q = CODE_MOVING;
						elapsed_q = '0;
						ev = EV_TRANSIT;
					end else begin
						mode_q = CODE_IDLE;
						ev = EV_IDLE;
					end
				end
			end
			CODE_MOVING: begin
				if (elapsed_q > travel_ms) begin
					old = floor_q;
					if (head_q == HEAD_UP && floor_q < TOP_FLOOR) floor_q++;
					else if (head_q == HEAD_DOWN && floor_q != 4'd0) floor_q--;
					elapsed_q = '0;
					passed = (floor_q != old);
					if (calls_q[floor_q]) begin
						calls_q[floor_q] = 1'b0;
						mode_q = CODE_ARRIVED;
						ev = EV_ARRIVED;
					end else begin
						ahead = (head_q == HEAD_UP) ? pending_up() : pending_down();
						behind = (head_q == HEAD_UP) ? pending_down() : pending_up();
						if (!ahead) begin
							if (behind) begin
								head_q = -head_q;
								ev = EV_TRANSIT;
							end else begin
								mode_q = CODE_IDLE;
								head_q = HEAD_NONE;
								ev = EV_IDLE;
							end
						end
					end
				end
			end
			CODE_ARRIVED: begin
				if (elapsed_q > settle_ms) begin
					mode_q = CODE_OPENING;
					elapsed_q = '0;
					ev = EV_OPENING;
				end
			end
			CODE_OPENING: begin
				if (elapsed_q > door_ms) begin
					mode_q = CODE_OPEN;
					elapsed_q = '0;
				end
			end
			default: ;
		endcase
		return ev;
	endfunction

	// Applies one accepted command to the predicted state and queues the result.
	function automatic void car_step(input logic [2:0] c, input logic [3:0] req,
			input logic over);
		car_view_t v;
		logic [3:0] ev;
		logic       passed;
		ev = EV_NONE;
		passed = 1'b0;
		case (c)
			CMD_TICK: ev = run_car_tick(passed);
			CMD_FLOOR_CALL: begin
				if (!lock_q && req < TOP_FLOOR) begin
					if (req == floor_q) begin
						if (mode_q == CODE_IDLE) begin
							mode_q = CODE_OPENING;
							elapsed_q = '0;
							ev = EV_OPENING;
						end
					end else begin
						calls_q[req] = 1'b1;
						ev = EV_CALL;
					end
				end
			end
			CMD_SECURE: begin
				if (!lock_q) begin
					calls_q[TOP_FLOOR] = 1'b1;
					ev = EV_SECURE;
				end
			end
			CMD_OPEN: begin
				if (mode_q == CODE_IDLE || mode_q == CODE_OPEN) begin
					mode_q = CODE_OPENING;
					elapsed_q = '0;
					ev = EV_OPENING;
				end
			end
			CMD_CLOSE: begin
				if (mode_q == CODE_OPEN) begin
					mode_q = CODE_CLOSING;
					elapsed_q = '0;
					ev = EV_CLOSING;
				end
			end
			CMD_ESTOP: begin
				lock_q = 1'b1;
				ev = EV_LOCK;
			end
			CMD_WEIGHT: begin
				if (over && !lock_q) begin
					lock_q = 1'b1;
					ev = EV_LOCK;
				end else if (!over && lock_q) begin
					lock_q = 1'b0;
					ev = EV_UNLOCKED;
				end
			end
			default: ;
		endcase
		v.mode = mode_q;
		v.floor = floor_q;
		v.dir = head_q;
		v.locked = lock_q;
		v.ev = ev;
		v.passed = passed;
		views_due.push_back(v);
	endfunction

	// Sends one command and updates the prediction once the transaction is taken.
	task automatic issue_command(input logic [2:0] c, input logic [3:0] f, input logic o);
		if (idling && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= c;
		floor <= f;
		over_limit <= o;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		car_step(c, f, o);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (views_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_timing(input logic [15:0] door, input logic [15:0] settle,
			input logic [15:0] travel);
		drain_results();
		cfg_write <= 1'b1;
		cfg_index <= REG_DOOR_TIME;
		cfg_data <= door;
		@(posedge clk);
		door_ms = door;
		cfg_index <= REG_SETTLE_TIME;
		cfg_data <= settle;
		@(posedge clk);
		settle_ms = settle;
		cfg_index <= REG_TRAVEL_TIME;
		cfg_data <= travel;
		@(posedge clk);
		travel_ms = travel;
		// A write to the unused index must leave every register alone.
		cfg_index <= REG_SPARE;
		cfg_data <= 16'($urandom);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// Serves every pending call and closes the doors until the car sits idle.
	task automatic bring_to_rest();
		if (lock_q) issue_command(CMD_WEIGHT, 4'($urandom), 1'b0);
		for (int n = 0; n < 500 && mode_q != CODE_IDLE; n++)
			issue_command((mode_q == CODE_OPEN) ? CMD_CLOSE : CMD_TICK,
				4'($urandom), 1'($urandom));
	endtask

	// With the reset door time the opening is still under way after these ticks.
	task automatic test_reset_timing();
		idling = 1'b0;
		issue_command(CMD_OPEN, 4'd0, 1'b0);
		repeat (40) issue_command(CMD_TICK, 4'($urandom), 1'($urandom));
	endtask

	task automatic test_directed_cases();
		set_timing(16'd1, 16'd0, 16'd2);
		idling = 1'b1;
		issue_command(CMD_FLOOR_CALL, TOP_FLOOR, 1'b0);
		issue_command(CMD_FLOOR_CALL, 4'hF, 1'b1);
		issue_command(CMD_FLOOR_CALL, floor_q, 1'b0);
		issue_command(CMD_OPEN, 4'd0, 1'b0);
		issue_command(CMD_CLOSE, 4'd0, 1'b0);
		issue_command(CMD_UNUSED, 4'hA, 1'b1);
		issue_command(CMD_TICK, 4'd5, 1'b0);
		issue_command(CMD_TICK, 4'd0, 1'b1);
		issue_command(CMD_CLOSE, 4'd0, 1'b0);
		issue_command(CMD_SECURE, 4'd0, 1'b0);
		issue_command(CMD_FLOOR_CALL, 4'd2, 1'b0);
		issue_command(CMD_FLOOR_CALL, 4'd5, 1'b0);
		bring_to_rest();
		// The car runs down from the top past floors without calls.
		issue_command(CMD_FLOOR_CALL, 4'd4, 1'b0);
		bring_to_rest();
		issue_command(CMD_ESTOP, 4'd0, 1'b0);
		issue_command(CMD_ESTOP, 4'd0, 1'b0);
		issue_command(CMD_FLOOR_CALL, 4'd3, 1'b0);
		issue_command(CMD_SECURE, 4'd0, 1'b0);
		// Locked but not yet in overload mode, so the doors still open.
		issue_command(CMD_OPEN, 4'd0, 1'b0);
		issue_command(CMD_WEIGHT, 4'd0, 1'b1);
		issue_command(CMD_TICK, 4'd0, 1'b0);
		issue_command(CMD_WEIGHT, 4'd0, 1'b0);
		issue_command(CMD_WEIGHT, 4'd0, 1'b0);
		issue_command(CMD_TICK, 4'd0, 1'b0);
		bring_to_rest();
		issue_command(CMD_FLOOR_CALL, floor_q, 1'b0);
		issue_command(CMD_WEIGHT, 4'd0, 1'b1);
		issue_command(CMD_WEIGHT, 4'd0, 1'b0);
	endtask

	// With the door time at its maximum the opening does not end here; a shorter
	// door time written afterward must then end the opening on the next tick.
	task automatic test_long_door_time();
		bring_to_rest();
		set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
		idling = 1'b0;
		issue_command(CMD_OPEN, 4'd0, 1'b0);
		repeat (20) issue_command(CMD_TICK, 4'($urandom), 1'($urandom));
		set_timing(16'd3, 16'hFFFF, 16'hFFFF);
		repeat (3) issue_command(CMD_TICK, 4'($urandom), 1'($urandom));
	endtask

	task automatic random_phase(input logic [15:0] door, input logic [15:0] settle,
			input logic [15:0] travel, input int count, input bit with_idling);
		int         r;
		logic [2:0] c;
		logic [3:0] f;
		logic       o;
		set_timing(door, settle, travel);
		idling = with_idling;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			f = 4'($urandom_range(0, 15));
			o = 1'($urandom_range(0, 1));
			if (r < 55) begin
				c = CMD_TICK;
			end else if (r < 72) begin
				c = CMD_FLOOR_CALL;
				if ($urandom_range(0, 3) != 0) f = 4'($urandom_range(0, TOP_FLOOR - 1));
			end else if (r < 75) begin
				c = CMD_SECURE;
			end else if (r < 80) begin
				c = CMD_OPEN;
			end else if (r < 89) begin
				c = CMD_CLOSE;
			end else if (r < 91) begin
				c = CMD_ESTOP;
			end else if (r < 98) begin
				c = CMD_WEIGHT;
				o = ($urandom_range(0, 2) == 0);
			end else begin
				c = CMD_UNUSED;
			end
			issue_command(c, f, o);
		end
	endtask

	task automatic test_random_traffic();
		random_phase(16'd0, 16'd0, 16'd0, 150, 1'b1);
		random_phase(16'd1, 16'd3, 16'd2, 150, 1'b1);
		random_phase(16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
			16'($urandom_range(0, 6)), 150, 1'b1);
		random_phase(16'd0, 16'hFFFF, 16'd1, 100, 1'b1);
		random_phase(16'd2, 16'd1, 16'd3, 200, 1'b0);
	endtask

	// Receiver side: stalls in random bursts while idling is enabled.
	always @(posedge clk) begin
		if (stall_left > 0) stall_left--;
		else if (idling && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 10);
		out_stall <= (stall_left > 0);
	end

	always @(posedge clk) begin : check_results
		car_view_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got.mode = mode;
			got.floor = car_floor;
			got.dir = direction;
			got.locked = locked;
			got.ev = event_res;
			got.passed = floor_passed;
			if (views_due.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("unexpected result transaction at %0t", $realtime);
			end else begin
				want = views_due.pop_front();
				if (got.mode !== want.mode || got.floor !== want.floor ||
						got.dir !== want.dir || got.locked !== want.locked ||
						got.ev !== want.ev || got.passed !== want.passed) begin
					errors++;
					if (errors <= REPORT_LIMIT) begin
						$display("result mismatch at %0t (expected/actual):", $realtime);
						$display("  mode %0d/%0d floor %0d/%0d dir %0d/%0d",
							want.mode, got.mode, want.floor, got.floor,
							$signed(want.dir), $signed(got.dir));
						$display("  lock %0b/%0b event %0d/%0d passed %0b/%0b",
							want.locked, got.locked, want.ev, got.ev,
							want.passed, got.passed);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_DOOR_TIME;
		cfg_data = '0;
		in_valid = 1'b0;
		command = CMD_TICK;
		floor = '0;
		over_limit = 1'b0;
		out_stall = 1'b0;
		idling = 1'b0;
		mode_q = CODE_IDLE;
		floor_q = '0;
		head_q = HEAD_NONE;
		calls_q = '0;
		elapsed_q = '0;
		lock_q = 1'b0;
		door_ms = DOOR_TIME_RST;
		settle_ms = SETTLE_TIME_RST;
		travel_ms = TRAVEL_TIME_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_timing();
		test_directed_cases();
		test_long_door_time();
		test_random_traffic();
		drain_results();
		repeat (4) @(posedge clk);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
